// ===== design/tpm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpm_pkg: shared constants and types of the tachometer period meter
// Field widths, register reset values, register indexes and the edge check
// result bundle.
// ----------------------------------------------------------------------------
package tpm_pkg;

   localparam int TIME_W = 32;                 // timestamp and period width
   localparam int MINP_W = 20;                 // min_period_us width
   localparam int RPS_W  = 28;                 // rps_q8 and min_rps_q8 width
   localparam int CSR_W  = 28;                 // widest register
   localparam int CSR_AW = 1;                  // register index width

   localparam int US_PER_S = 1000000;          // microseconds per second
   localparam int US_BITS  = 20;               // bits needed for US_PER_S

   localparam int DEF_CHANNELS  = 2;
   localparam int DEF_FRAC_BITS = 8;

   localparam logic [MINP_W-1:0] MINP_RESET   = MINP_W'(1000);
   localparam logic [RPS_W-1:0]  MINRPS_RESET = RPS_W'(256);

   localparam logic [CSR_AW-1:0] CSR_MIN_PERIOD = 1'b0;
   localparam logic [CSR_AW-1:0] CSR_MIN_RPS    = 1'b1;

   typedef struct packed {
      logic              done;        // one-cycle pulse, fields below valid
      logic              accept;      // edge passed both interval rules
      logic [TIME_W-1:0] since_fall;  // wrapped time since last falling edge
   } chk_res_type;

endpackage

// ===== design/tpm_edge_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpm_edge_check: bit-serial glitch rejection check
// Forms the wrapped differences to the last rise and fall and compares them
// against the full and half minimum period, one bit per cycle, LSB first.
// ----------------------------------------------------------------------------
module tpm_edge_check (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic                             level,
   input  logic [tpm_pkg::TIME_W-1:0]       t,
   input  logic [tpm_pkg::TIME_W-1:0]       rise,
   input  logic [tpm_pkg::TIME_W-1:0]       fall,
   input  logic [tpm_pkg::MINP_W-1:0]       full,
   output tpm_pkg::chk_res_type             res
);

   localparam int TW = tpm_pkg::TIME_W;
   localparam int CW = $clog2(TW);

   logic          busy_ff, done_ff, lvl_ff;
   logic [CW-1:0] cnt_ff;
   logic [TW-1:0] t_sh_ff, r_sh_ff, f_sh_ff, lim_sh_ff, sf_ff;
   // borrow of t-rise, t-fall, and of the compares against full / half
   logic          br_ff, bf_ff, brf_ff, brh_ff, bff_ff, bfh_ff;
   logic          br_in, bf_in, brf_in, brh_in, bff_in, bfh_in;
   logic          dr, df;

   function automatic logic borrow(input logic a, input logic b, input logic bin);
      borrow = (~a & b) | (~(a ^ b) & bin);
   endfunction

   always_comb begin
      dr     = t_sh_ff[0] ^ r_sh_ff[0] ^ br_ff;
      df     = t_sh_ff[0] ^ f_sh_ff[0] ^ bf_ff;
      br_in  = borrow(t_sh_ff[0], r_sh_ff[0], br_ff);
      bf_in  = borrow(t_sh_ff[0], f_sh_ff[0], bf_ff);
      // half limit bit i is full limit bit i+1
      brf_in = borrow(dr, lim_sh_ff[0], brf_ff);
      brh_in = borrow(dr, lim_sh_ff[1], brh_ff);
      bff_in = borrow(df, lim_sh_ff[0], bff_ff);
      bfh_in = borrow(df, lim_sh_ff[1], bfh_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         // pulse done on the last bit step
         done_ff <= busy_ff && !start && (cnt_ff == CW'(TW - 1));
         if (start) begin
            busy_ff   <= 1'b1;
            cnt_ff    <= '0;
            lvl_ff    <= level;
            t_sh_ff   <= t;
            r_sh_ff   <= rise;
            f_sh_ff   <= fall;
            lim_sh_ff <= TW'(full);
            br_ff     <= 1'b0;
            bf_ff     <= 1'b0;
            brf_ff    <= 1'b0;
            brh_ff    <= 1'b0;
            bff_ff    <= 1'b0;
            bfh_ff    <= 1'b0;
         end else if (busy_ff) begin
            t_sh_ff   <= {1'b0, t_sh_ff[TW-1:1]};
            r_sh_ff   <= {1'b0, r_sh_ff[TW-1:1]};
            f_sh_ff   <= {1'b0, f_sh_ff[TW-1:1]};
            lim_sh_ff <= {1'b0, lim_sh_ff[TW-1:1]};
            sf_ff     <= {df, sf_ff[TW-1:1]};
            br_ff     <= br_in;
            bf_ff     <= bf_in;
            brf_ff    <= brf_in;
            brh_ff    <= brh_in;
            bff_ff    <= bff_in;
            bfh_ff    <= bfh_in;
            cnt_ff    <= cnt_ff + 1'b1;
            if (cnt_ff == CW'(TW - 1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   // no final borrow means difference >= limit
   assign res.done       = done_ff;
   assign res.accept     = lvl_ff ? (!bfh_ff && !brf_ff) : (!brh_ff && !bff_ff);
   assign res.since_fall = sf_ff;

endmodule

// ===== design/tpm_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpm_divider: bit-serial restoring divider
// Divides the constant 1e6 << FRAC_BITS by a 32-bit period, one quotient
// bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module tpm_divider #(
   parameter int FRAC_BITS = tpm_pkg::DEF_FRAC_BITS
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            start,
   input  logic [tpm_pkg::TIME_W-1:0]                      divisor,
   output logic                                            done,
   output logic [tpm_pkg::US_BITS+FRAC_BITS-1:0]           quot
);

   localparam int TW = tpm_pkg::TIME_W;
   localparam int DW = tpm_pkg::US_BITS + FRAC_BITS;
   localparam int CW = $clog2(DW);
   localparam logic [DW-1:0] DIVIDEND = DW'(tpm_pkg::US_PER_S) << FRAC_BITS;

   logic          busy_ff, done_ff;
   logic [CW-1:0] cnt_ff;
   logic [DW-1:0] dvd_ff, q_ff;
   logic [TW-1:0] rem_ff, dvs_ff;
   logic [TW:0]   cand;
   logic [TW+1:0] diff;
   logic          ge;
   logic [TW-1:0] rem_in;

   always_comb begin
      cand   = {rem_ff, dvd_ff[DW-1]};
      diff   = {1'b0, cand} - {2'b00, dvs_ff};
      ge     = !diff[TW+1];
      rem_in = ge ? diff[TW-1:0] : cand[TW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         // pulse done on the last quotient bit
         done_ff <= busy_ff && !start && (cnt_ff == CW'(DW - 1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            dvd_ff  <= DIVIDEND;
            dvs_ff  <= divisor;
            rem_ff  <= '0;
            q_ff    <= '0;
         end else if (busy_ff) begin
            dvd_ff <= {dvd_ff[DW-2:0], 1'b0};
            rem_ff <= rem_in;
            q_ff   <= {q_ff[DW-2:0], ge};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CW'(DW - 1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

// ===== design/tach_period_rps_meter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tach_period_rps_meter: two-channel tachometer with glitch rejection
// Measures falling-to-falling periods per channel and reports speed in
// revolutions per second as unsigned fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one transaction per pin edge. tuser carries channel and level,
//            tdata the 32-bit microsecond timestamp (wraps freely).
//   rsp_*  : exactly one transaction per request, in order: channel, accept
//            flag, the channel's period and its speed (Q8 by default).
//   csr_*  : write-only registers, to be written by the user only while the
//            block is idle; the block itself leaves this unchecked.
// Flow: an edge runs a bit-serial interval check, then, if the period is
//   nonzero, a bit-serial divider; with no period yet the divider is
//   skipped, and a request for an unknown channel skips both. One edge is
//   in work at a time: a new request is taken only after the previous
//   result has been loaded into the output register.
// Reset clears the stored rise, fall and period times of every channel and
//   loads the register defaults (min period 1000 us, min speed 256).
// A stalled receiver holds the result in the output register; the next
//   request is still taken and worked, and waits for the output to drain.
// ----------------------------------------------------------------------------
module tach_period_rps_meter #(
   parameter int CHANNELS  = tpm_pkg::DEF_CHANNELS,
   parameter int FRAC_BITS = tpm_pkg::DEF_FRAC_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   // request: tuser = channel, level ; tdata = time_us
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [31:0]                  req_tdata,
   input  logic [1:0]                   req_tuser,
   // response: tuser = out_channel, accepted ; tdata = period_us, rps_q8, pad
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [63:0]                  rsp_tdata,
   output logic [1:0]                   rsp_tuser,
   // register write port
   input  logic                         csr_we,
   input  logic [tpm_pkg::CSR_AW-1:0]   csr_addr,
   input  logic [tpm_pkg::CSR_W-1:0]    csr_wdata
);

   localparam int TW   = tpm_pkg::TIME_W;
   localparam int RW   = tpm_pkg::RPS_W;
   localparam int DW   = tpm_pkg::US_BITS + FRAC_BITS;
   localparam int QX   = (DW > RW) ? DW : RW;
   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   typedef enum logic [1:0] {S_IDLE, S_CHECK, S_DIV, S_OUT} state_type;

   state_type                      state_ff;
   logic                           ch_ff, lvl_ff, acc_ff, zero_ff;
   logic [TW-1:0]                  t_ff, p_ff;
   logic                           rsp_tvalid_ff, rsp_ch_ff, rsp_acc_ff;
   logic [TW-1:0]                  rsp_period_ff;
   logic [RW-1:0]                  rsp_rps_ff;

   logic [tpm_pkg::MINP_W-1:0]     min_period_ff;
   logic [RW-1:0]                  min_rps_ff;

   logic [TW-1:0]                  rise_ff   [CHANNELS];
   logic [TW-1:0]                  fall_ff   [CHANNELS];
   logic [TW-1:0]                  period_ff [CHANNELS];

   logic                           req_fire, req_valid_ch, chk_start, div_start, out_load;
   logic [CH_W-1:0]                req_idx, idx;
   logic [TW-1:0]                  p_in;
   tpm_pkg::chk_res_type           chk;
   logic                           div_done;
   logic [DW-1:0]                  div_quot;
   logic [QX-1:0]                  q_ext;
   logic [RW-1:0]                  rps_sat, rps_in;

   // ---------------------------------------------------------------------
   // Handshake and decode
   // ---------------------------------------------------------------------
   assign req_tready   = (state_ff == S_IDLE);
   assign req_fire     = req_tvalid && req_tready;
   assign req_valid_ch = (32'(req_tuser[0]) < CHANNELS);
   assign req_idx      = CH_W'(req_tuser[0]);
   assign idx          = CH_W'(ch_ff);
   assign chk_start    = req_fire && req_valid_ch;

   // Period after this edge: a taken falling edge records the new one.
   assign p_in      = (chk.accept && !lvl_ff) ? chk.since_fall : period_ff[idx];
   assign div_start = (state_ff == S_CHECK) && chk.done && (p_in != '0);
   assign out_load  = (state_ff == S_OUT) && (!rsp_tvalid_ff || rsp_tready);

   // Saturate to the field, then drop speeds below the floor.
   always_comb begin
      q_ext   = QX'(div_quot);
      rps_sat = (|(q_ext >> RW)) ? '1 : q_ext[RW-1:0];
      if (zero_ff || (rps_sat < min_rps_ff)) begin
         rps_in = '0;
      end else begin
         rps_in = rps_sat;
      end
   end

   // ---------------------------------------------------------------------
   // Serial units
   // ---------------------------------------------------------------------
   tpm_edge_check u_check (
      .clock (clock),
      .reset (reset),
      .start (chk_start),
      .level (req_tuser[1]),
      .t     (req_tdata),
      .rise  (rise_ff[req_idx]),
      .fall  (fall_ff[req_idx]),
      .full  (min_period_ff),
      .res   (chk)
   );

   tpm_divider #(
      .FRAC_BITS (FRAC_BITS)
   ) u_divider (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .divisor (p_in),
      .done    (div_done),
      .quot    (div_quot)
   );

   // ---------------------------------------------------------------------
   // Sequencer and output register
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         // load a new result, else drop the one just taken
         if (out_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tvalid_ff && rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  ch_ff  <= req_tuser[0];
                  lvl_ff <= req_tuser[1];
                  t_ff   <= req_tdata;
                  if (req_valid_ch) begin
                     state_ff <= S_CHECK;
                  end else begin
                     // unknown channel: report nothing measured
                     acc_ff   <= 1'b0;
                     p_ff     <= '0;
                     zero_ff  <= 1'b1;
                     state_ff <= S_OUT;
                  end
               end
            end
            S_CHECK: begin
               if (chk.done) begin
                  acc_ff  <= chk.accept;
                  p_ff    <= p_in;
                  zero_ff <= (p_in == '0);
                  state_ff <= (p_in == '0) ? S_OUT : S_DIV;
               end
            end
            S_DIV: begin
               if (div_done) begin
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (out_load) begin
                  rsp_ch_ff     <= ch_ff;
                  rsp_acc_ff    <= acc_ff;
                  rsp_period_ff <= p_ff;
                  rsp_rps_ff    <= rps_in;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Per-channel edge history: update on an accepted edge
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            rise_ff[i]   <= '0;
            fall_ff[i]   <= '0;
            period_ff[i] <= '0;
         end
      end else if ((state_ff == S_CHECK) && chk.done && chk.accept) begin
         if (lvl_ff) begin
            rise_ff[idx] <= t_ff;
         end else begin
            period_ff[idx] <= chk.since_fall;
            fall_ff[idx]   <= t_ff;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         min_period_ff <= tpm_pkg::MINP_RESET;
         min_rps_ff    <= tpm_pkg::MINRPS_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            tpm_pkg::CSR_MIN_PERIOD: min_period_ff <= csr_wdata[tpm_pkg::MINP_W-1:0];
            tpm_pkg::CSR_MIN_RPS:    min_rps_ff    <= csr_wdata[RW-1:0];
            default: ;
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = {rsp_acc_ff, rsp_ch_ff};
   assign rsp_tdata  = {4'b0000, rsp_rps_ff, rsp_period_ff};

endmodule

// ===== bench/tach_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tach_checker: scoreboard of the tachometer period meter
// Mirrors the register writes, predicts one reading per taken request and
// compares every response transaction with the oldest pending reading.
// ----------------------------------------------------------------------------
module tach_checker #(
   parameter int FRAC_BITS = tpm_pkg::DEF_FRAC_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   input  logic                       req_tready,
   input  logic [31:0]                req_tdata,
   input  logic [1:0]                 req_tuser,
   input  logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic [63:0]                rsp_tdata,
   input  logic [1:0]                 rsp_tuser,
   input  logic                       csr_we,
   input  logic [tpm_pkg::CSR_AW-1:0] csr_addr,
   input  logic [tpm_pkg::CSR_W-1:0]  csr_wdata,
   output int                         fail_count,
   output int                         pending
);
   import tpm_pkg::*;

   localparam int MAX_SHOWN = 40;
   localparam logic [RPS_W-1:0] RPS_MAX = '1;

   typedef struct packed {
      logic              ch;
      logic              acc;
      logic [TIME_W-1:0] period;
      logic [RPS_W-1:0]  rps;
   } reading_type;

   logic [TIME_W-1:0] rise_at   [DEF_CHANNELS];
   logic [TIME_W-1:0] fall_at   [DEF_CHANNELS];
   logic [TIME_W-1:0] period_of [DEF_CHANNELS];
   logic [MINP_W-1:0] min_period;
   logic [RPS_W-1:0]  min_rps;
   reading_type       readings_q[$];
   int                n_fail = 0;
   int                n_shown = 0;

   assign fail_count = n_fail;

   // Saturated reciprocal speed, zero below min_rps; a missing period reads as zero.
   function automatic logic [RPS_W-1:0] rps_from_period(input logic [TIME_W-1:0] p);
      logic [63:0] q;
      if (p == '0) return '0;
      q = (64'(US_PER_S) << FRAC_BITS) / 64'(p);
      if (q > 64'(RPS_MAX)) q = 64'(RPS_MAX);
      if (q < 64'(min_rps)) return '0;
      return q[RPS_W-1:0];
   endfunction

   // Apply the glitch rules to one edge and update the channel's times.
   function automatic reading_type measure_edge(input logic ch, input logic lvl,
                                                input logic [TIME_W-1:0] t);
      logic [TIME_W-1:0] since_rise;
      logic [TIME_W-1:0] since_fall;
      logic [TIME_W-1:0] full;
      logic [TIME_W-1:0] half;
      reading_type       r;
      full = TIME_W'(min_period);
      half = full >> 1;
      since_rise = t - rise_at[ch];
      since_fall = t - fall_at[ch];
      r.ch  = ch;
      r.acc = 1'b0;
      if (lvl) begin
         if (since_fall >= half && since_rise >= full) begin
            rise_at[ch] = t;
            r.acc = 1'b1;
         end
      end else begin
         if (since_rise >= half && since_fall >= full) begin
            period_of[ch] = since_fall;
            fall_at[ch] = t;
            r.acc = 1'b1;
         end
      end
      r.period = period_of[ch];
      r.rps = rps_from_period(period_of[ch]);
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      n_fail++;
      // keep the log short on a badly broken block
      if (n_shown < MAX_SHOWN) begin
         n_shown++;
         $display("%0t checker: %s: got %0h, expected %0h", $time, what, got, want);
      end
   endtask

   always @(posedge clock) begin : watch
      reading_type want;
      if (reset) begin
         min_period = MINP_RESET;
         min_rps = MINRPS_RESET;
         for (int i = 0; i < DEF_CHANNELS; i++) begin
            rise_at[i] = '0;
            fall_at[i] = '0;
            period_of[i] = '0;
         end
         readings_q.delete();
      end else begin
         // retire before predicting: a response never belongs to this cycle's edge
         if (rsp_tvalid && rsp_tready) begin
            if (readings_q.size() == 0) begin
               report_mismatch("response with no reading pending", rsp_tdata, '0);
            end else begin
               want = readings_q.pop_front();
               if (rsp_tuser[0] !== want.ch)
                  report_mismatch("out_channel", 64'(rsp_tuser[0]), 64'(want.ch));
               if (rsp_tuser[1] !== want.acc)
                  report_mismatch("accepted", 64'(rsp_tuser[1]), 64'(want.acc));
               if (rsp_tdata[31:0] !== want.period)
                  report_mismatch("period_us", 64'(rsp_tdata[31:0]), 64'(want.period));
               if (rsp_tdata[59:32] !== want.rps)
                  report_mismatch("rps_q8", 64'(rsp_tdata[59:32]), 64'(want.rps));
               if (rsp_tdata[63:60] !== 4'h0)
                  report_mismatch("tdata padding", 64'(rsp_tdata[63:60]), '0);
            end
         end
         if (req_tvalid && req_tready)
            readings_q.push_back(measure_edge(req_tuser[0], req_tuser[1], req_tdata));
         if (csr_we) begin
            if (csr_addr == CSR_MIN_PERIOD)
               min_period = csr_wdata[MINP_W-1:0];
            else if (csr_addr == CSR_MIN_RPS)
               min_rps = csr_wdata[RPS_W-1:0];
         end
      end
      pending = readings_q.size();
   end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the two-channel tachometer period meter
// Drives pin edges and register settings, stalls both sides at random and
// leaves prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module tb;
   import tpm_pkg::*;

   localparam int LATENCY_GAP    = 100;   // settle time after every reading is back
   localparam int WATCHDOG_LIMIT = 4000;  // cycles without any transaction
   localparam int RANDOM_CHUNKS  = 6;
   localparam int CHUNK_ITEMS    = 240;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [31:0]       req_tdata = '0;   // time_us
   logic [1:0]        req_tuser = '0;   // [0] channel, [1] level
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [63:0]       rsp_tdata;        // [31:0] period_us, [59:32] rps_q8, [63:60] zero
   logic [1:0]        rsp_tuser;        // [0] out_channel, [1] accepted
   logic              csr_we = 1'b0;
   logic [CSR_AW-1:0] csr_addr = '0;
   logic [CSR_W-1:0]  csr_wdata = '0;

   int                fail_count;
   int                pending;
   int                send_idle = 26;   // percent of cycles the sender holds off
   int                recv_idle = 78;   // percent of cycles the receiver stalls
   int                stall_cycles = 0;
   logic [31:0]       cur_t   [2];      // last timestamp issued per channel
   logic              nxt_lvl [2];      // level the next clean edge takes
   logic [MINP_W-1:0] cfg_minp = MINP_RESET;

   tach_period_rps_meter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   tach_checker chk (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #5 clock = ~clock;

   // Stall the receiver at random; change it only on the falling edge.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle);
   end

   // Abort when no transaction moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: FAIL");
            $finish;
         end
      end
   end

   // Offer one edge and hold it until the block takes the transaction.
   // Enter and leave on a falling edge; tvalid stays high on exit so the
   // next call can keep it up without a dip.
   task automatic send_edge(input logic ch, input logic lvl, input logic [31:0] t);
      while ($urandom_range(0, 99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= {lvl, ch};
      req_tdata  <= t;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Drop tvalid, wait for every pending reading, then let the block settle.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (LATENCY_GAP) @(negedge clock);
   endtask

   // Write both registers; call only while the block is idle.
   task automatic write_limits(input logic [MINP_W-1:0] minp, input logic [RPS_W-1:0] minrps);
      cfg_minp  = minp;
      csr_we    <= 1'b1;
      csr_addr  <= CSR_MIN_PERIOD;
      csr_wdata <= CSR_W'(minp);
      @(negedge clock);
      csr_addr  <= CSR_MIN_RPS;
      csr_wdata <= CSR_W'(minrps);
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // Mostly a clean square wave per channel with random high and low times;
   // mix in short glitches, exact threshold intervals, big jumps across the
   // timestamp wrap and plain noise.
   task automatic random_edge();
      logic        ch;
      logic        lvl;
      logic [31:0] t;
      logic [31:0] delta;
      int unsigned full;
      int unsigned half;
      int unsigned pick;
      full = 32'(cfg_minp);
      half = full / 2;
      ch   = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         lvl = 1'($urandom_range(0, 1));
         t   = $urandom;
      end else begin
         lvl = nxt_lvl[ch];
         if (pick < 20)
            delta = $urandom_range(0, half);
         else if (pick < 23)
            delta = $urandom;
         else if (pick < 28)
            delta = $urandom_range(0, 1) ? half : full;
         else
            delta = $urandom_range(half, 2 * full);
         t = cur_t[ch] + delta;
      end
      cur_t[ch]   = t;
      nxt_lvl[ch] = ~lvl;
      send_edge(ch, lvl, t);
   endtask

   initial begin : stimulus
      int unsigned minp;
      int unsigned minrps;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // Directed: no period yet, both threshold boundaries, wrap, slow speed
      send_edge(1'b0, 1'b1, 32'd0);             // too close to the reset times
      send_edge(1'b0, 1'b1, 32'd1000);          // exactly one full interval
      send_edge(1'b0, 1'b0, 32'd1499);          // one short of half
      send_edge(1'b0, 1'b0, 32'd1500);          // exactly half, first period
      send_edge(1'b0, 1'b1, 32'd2000);
      send_edge(1'b0, 1'b0, 32'd2999);
      send_edge(1'b1, 1'b0, 32'hFFFF_FFFF);     // huge period, speed below minimum
      send_edge(1'b1, 1'b1, 32'h0000_01F3);     // wraps past zero, rise too soon
      send_edge(1'b1, 1'b1, 32'h0000_03E8);
      send_edge(1'b1, 1'b1, 32'h0000_03E8);     // repeated timestamp
      send_edge(1'b1, 1'b0, 32'h0000_05DC);
      drain_results();
      write_limits(MINP_W'(2), RPS_W'(256000000));
      send_edge(1'b0, 1'b0, 32'd3001);          // shortest period, still below min speed
      send_edge(1'b0, 1'b1, 32'd3002);
      drain_results();
      write_limits(MINP_W'(2), RPS_W'(0));
      send_edge(1'b0, 1'b0, 32'd3003);          // top speed
      send_edge(1'b0, 1'b1, 32'd3003);
      drain_results();
      write_limits(MINP_W'(1000000), MINRPS_RESET);
      send_edge(1'b1, 1'b1, 32'hAAAA_AAAA);
      send_edge(1'b1, 1'b0, 32'h5555_5555);
      send_edge(1'b1, 1'b1, 32'h5555_5555 + 32'd499999);
      send_edge(1'b1, 1'b1, 32'h5555_5555 + 32'd500000);

      // Random: two chunks per idling mode, fresh limits before each chunk
      for (int i = 0; i < 2; i++) begin
         cur_t[i]   = $urandom;
         nxt_lvl[i] = 1'($urandom_range(0, 1));
      end
      for (int chunk = 0; chunk < RANDOM_CHUNKS; chunk++) begin
         drain_results();
         case (chunk / 2)
            0: begin send_idle = 26; recv_idle = 78; end
            1: begin send_idle = 78; recv_idle = 26; end
            default: begin send_idle = 0; recv_idle = 0; end
         endcase
         case (chunk)
            0: begin
               minp = $urandom_range(50, 5000);
               minrps = 256000000 / $urandom_range(minp, 3 * minp);
            end
            1: begin
               minp = 2;
               minrps = 0;
            end
            2: begin
               minp = 1000000;
               minrps = 256000000;
            end
            3: begin
               minp = $urandom_range(2, 1000000);
               minrps = $urandom_range(0, 256000000);
            end
            4: begin
               minp = $urandom_range(2, 40);
               minrps = 256000000 / $urandom_range(minp, 3 * minp);
            end
            default: begin
               minp = $urandom_range(200, 999999) | 1;   // odd: half truncates
               minrps = 256000000 / $urandom_range(minp, 3 * minp);
            end
         endcase
         write_limits(MINP_W'(minp), RPS_W'(minrps));
         for (int n = 0; n < CHUNK_ITEMS; n++) begin
            // hold the sender once mid-chunk until every reading is back
            if (chunk == 2 && n == CHUNK_ITEMS / 2)
               drain_results();
            random_edge();
         end
      end

      drain_results();
      if (fail_count == 0 && pending == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule
